>>> rtl/core/cblv_pkg.sv
package cblv_pkg;

  // Field widths of one item.
  localparam int unsigned ENTRY_BITS = 24;
  localparam int unsigned DIM_BITS   = 16;
  localparam int unsigned BIT_IDX_W  = $clog2(ENTRY_BITS);
  localparam int unsigned PROD_BITS  = 2 * ENTRY_BITS;

  // Input item.
  typedef struct packed {
    logic [ENTRY_BITS-1:0] entry_count;
    logic [DIM_BITS-1:0]   dimension_count;
  } cblv_in_t;

  // Result item.
  typedef struct packed {
    logic [ENTRY_BITS-1:0] root_value;
    logic                  invalid;
  } cblv_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MULT,
    ST_DONE
  } cblv_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input item and clear the root
    logic setup;   // start a new candidate: product to one, step count to zero
    logic mult;    // one saturating multiply step
    logic decide;  // settle the current bit and move to the next one
    logic keep;    // with decide: the candidate fits, keep its bit
  } cblv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dims_zero;   // dimension count is zero
    logic cand_small;  // candidate is one (no multiply loop needed)
    logic entries_nz;  // entry count is nonzero
    logic over;        // next product passes the entry count
    logic last_mult;   // this multiply is the last one of the power
    logic bit_zero;    // the current bit is bit zero
  } cblv_status_t;

endpackage

>>> rtl/core/cblv_ctrl.sv
module cblv_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  output logic                  done_o,
  input  cblv_pkg::cblv_status_t status_i,
  output cblv_pkg::cblv_cmd_t    cmd_o
);
  import cblv_pkg::*;

  cblv_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (status_i.dims_zero) begin
          state_d = ST_DONE;
        end else if (status_i.cand_small) begin
          state_d = status_i.bit_zero ? ST_DONE : ST_SETUP;
        end else begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        if (status_i.over || status_i.last_mult) begin
          state_d = status_i.bit_zero ? ST_DONE : ST_SETUP;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        // A candidate of one fits whenever there is at least one entry.
        if (!status_i.dims_zero && status_i.cand_small) begin
          cmd_o.decide = 1'b1;
          cmd_o.keep   = status_i.entries_nz;
        end
      end
      ST_MULT: begin
        cmd_o.mult   = 1'b1;
        cmd_o.decide = status_i.over || status_i.last_mult;
        cmd_o.keep   = !status_i.over;
      end
      ST_DONE: begin
        cmd_o = '0;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

>>> rtl/core/cblv_dpath.sv
module cblv_dpath (
  input  logic                  clk_i,
  input  cblv_pkg::cblv_in_t    item_i,
  input  cblv_pkg::cblv_cmd_t   cmd_i,
  output cblv_pkg::cblv_status_t status_o,
  output cblv_pkg::cblv_out_t   result_o
);
  import cblv_pkg::*;

  logic [ENTRY_BITS-1:0] entries_q;
  logic [DIM_BITS-1:0]   dims_q;
  logic [ENTRY_BITS-1:0] root_q, root_d;
  logic [BIT_IDX_W-1:0]  bit_idx_q, bit_idx_d;
  logic [ENTRY_BITS-1:0] acc_q, acc_d;
  logic [DIM_BITS-1:0]   step_q, step_d;
  logic [ENTRY_BITS-1:0] cand;
  logic [PROD_BITS-1:0]  prod;

  // Candidate: the root so far with the current bit set.
  assign cand = root_q | (ENTRY_BITS'(1) << bit_idx_q);

  // One saturating multiply step of the candidate power.
  assign prod = PROD_BITS'(acc_q) * PROD_BITS'(cand);

  // Status toward the controller.
  assign status_o.dims_zero  = (dims_q == '0);
  assign status_o.cand_small = (cand[ENTRY_BITS-1:1] == '0);
  assign status_o.entries_nz = (entries_q != '0);
  assign status_o.over       = (prod > PROD_BITS'(entries_q));
  assign status_o.last_mult  = (step_q == (dims_q - DIM_BITS'(1)));
  assign status_o.bit_zero   = (bit_idx_q == '0);

  // Next values of the search registers.
  always_comb begin
    root_d    = root_q;
    bit_idx_d = bit_idx_q;
    acc_d     = acc_q;
    step_d    = step_q;
    if (cmd_i.load) begin
      root_d    = '0;
      bit_idx_d = BIT_IDX_W'(ENTRY_BITS - 1);
    end
    if (cmd_i.setup) begin
      acc_d  = ENTRY_BITS'(1);
      step_d = '0;
    end
    if (cmd_i.mult && !status_o.over) begin
      acc_d  = prod[ENTRY_BITS-1:0];
      step_d = step_q + DIM_BITS'(1);
    end
    if (cmd_i.decide) begin
      if (cmd_i.keep) root_d = cand;
      if (!status_o.bit_zero) bit_idx_d = bit_idx_q - BIT_IDX_W'(1);
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      entries_q <= item_i.entry_count;
      dims_q    <= item_i.dimension_count;
    end
    root_q    <= root_d;
    bit_idx_q <= bit_idx_d;
    acc_q     <= acc_d;
    step_q    <= step_d;
  end

  assign result_o.root_value = root_q;
  assign result_o.invalid    = status_o.dims_zero;

endmodule

>>> rtl/core/codebook_lookup_values_root.sv
// Integer root search: one result item per input item, always exactly one.
// The 24 root bits are settled one at a time, top bit first; a zero dimension
// count skips this. Each candidate above one runs the single saturating
// multiplier for its power. One item at a time: busy stays high through the
// strobe cycle, so the next item is taken in the cycle after the strobe.
// Reset (rst_ni low, asynchronous) returns the controller to idle; no clearing pass.
module codebook_lookup_values_root (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cblv_pkg::cblv_in_t  item_i,
  output logic                done_o,
  output cblv_pkg::cblv_out_t result_o
);
  import cblv_pkg::*;

  cblv_cmd_t    cmd;
  cblv_status_t status;

  // Sequencer for the bitwise search.
  cblv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Candidate, power and root registers with the multiplier.
  cblv_dpath u_dpath (
    .clk_i    (clk_i),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

>>> rtl/core/cblv_checker.sv
module cblv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input cblv_pkg::cblv_in_t  item_i,
  input logic                done_o,
  input cblv_pkg::cblv_out_t result_o
);
  import cblv_pkg::*;

  // An accepted item keeps the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  // A result appears only while the block is working on an item.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  // One result per item: the block is idle right after the strobe.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o) else $error("block still busy after result");

  // An invalid dimension count returns a zero root.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.invalid |-> result_o.root_value == '0)
    else $error("invalid result with nonzero root");

  // A zero dimension count is flagged on its result.
  a_zero_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.dimension_count == '0 |=> ##1 done_o && result_o.invalid)
    else $error("zero dimension count not flagged");

endmodule

bind codebook_lookup_values_root cblv_checker u_cblv_checker (.*);
